// ===== src/vca_pkg.sv =====
// Shared types and constants for the voice channel allocator.
// Used by vca_owner_search, vca_free_queue and voice_channel_allocator.
`default_nettype none

package vca_pkg;

  // Fixed field widths on the ports
  localparam int KEY_W        = 16;
  localparam int CMD_W        = 2;
  localparam int VOICE_W      = 6;
  localparam int COUNT_W      = 7;
  localparam int CFG_W        = 7;
  localparam int IN_DATA_W    = 16;
  localparam int OUT_FIELDS_W = 17;
  localparam int OUT_DATA_W   = 24;

  // Pool size after reset, before any register write
  localparam int TOTAL_RESET = 64;

  // Owner keys are stored eight to a memory row and compared a row per cycle
  localparam int LANES     = 8;
  localparam int LANE_BITS = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ASSIGN  = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_STOP    = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY
  } state_t;

  // Control toward the owner table
  typedef struct packed {
    logic refill;  // clear every owner
    logic start;   // begin a key search
    logic claim;   // record key as owner of a voice
    logic drop;    // clear the owner of a voice
  } vca_octl_t;

  // Control toward the free queue
  typedef struct packed {
    logic refill;  // reload the queue with voices in order
    logic rd;      // read the head entry
    logic pop;     // advance the head
    logic push;    // write at the tail and advance it
  } vca_qctl_t;

  // Search status back from the owner table
  typedef struct packed {
    logic done;    // one-cycle pulse at the end of a search
    logic found;   // key holds a voice, valid from done until next start
  } vca_hit_t;

endpackage

`default_nettype wire

// ===== src/voice_channel_allocator.sv =====
// Voice channel allocator top level: command sequencer, output register and config.
// Depends on vca_pkg, vca_owner_search and vca_free_queue.
//
// Usage
//   Command beats enter on the s_axis group: tuser carries the command
//   (assign, release, release and stop, query), tdata the 16-bit source key.
//   Each command yields exactly one result beat on the m_axis group with
//   ok, voice, was_playing, stop_request, active_count and any_free.
//   The cfg channel writes the pool size; every write refills the free FIFO
//   with voices 0..n-1 and clears all owners. Write it only while idle.
// Timing
//   A command's result waits on the owner search, which reads one memory row
//   of eight keys per cycle. One command is in work at a time; the next one
//   is accepted as soon as the previous result sits in the output register,
//   even while the receiver still holds it off.
// Reset
//   rst clears all owners and loads the FIFO with 64 voices (or VOICES if
//   fewer) in order. No clearing pass: per-entry flags clear at once.
// Stall
//   With m_axis_tready low the result holds in the output register and the
//   following command waits in its apply step until that beat leaves.
`default_nettype none

module voice_channel_allocator #(
  parameter int VOICES   = 64,
  parameter int KEY_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // command in
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [vca_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [15:0] source_key
  input  wire logic [vca_pkg::CMD_W-1:0]         s_axis_tuser,  // [1:0] cmd
  // result out
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] ok, [6:1] voice, [7] was_playing, [8] stop_request,
  // [15:9] active_count, [16] any_free, [23:17] zero
  output logic [vca_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // pool size register
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [vca_pkg::CFG_W-1:0]         cfg_data
);
  import vca_pkg::*;

  localparam int VB    = $clog2(VOICES);
  localparam int CB    = $clog2(VOICES + 1);
  localparam int PAD_W = OUT_DATA_W - OUT_FIELDS_W;

  state_t            state, state_next;
  cmd_t              cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [CB-1:0]     active;
  logic              out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  vca_octl_t         octl;
  vca_qctl_t         qctl;
  vca_hit_t          hit;
  logic [VB-1:0]     hit_voice;
  logic [VB-1:0]     qhead;
  logic [CB-1:0]     qcount;
  logic [VB-1:0]     wr_voice;

  logic              in_fire;
  logic              cfg_fire;
  logic              cfg_full;
  logic [CB-1:0]     cfg_count;
  logic [VB-1:0]     cfg_tail;

  logic              res_ok;
  logic              res_was;
  logic              res_stop;
  logic [VB-1:0]     res_voice;
  logic              take_pop;
  logic              take_push;
  logic [CB-1:0]     cnt_after;
  logic [CB-1:0]     active_after;
  logic              load_out;

  // Config has priority over a command beat arriving in the same cycle
  assign cfg_ready     = (state == ST_IDLE);
  assign s_axis_tready = (state == ST_IDLE) && !cfg_valid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_fire      = cfg_valid && cfg_ready;

  // Saturate the pool size at VOICES; a full pool wraps the tail to zero
  always_comb begin
    cfg_full  = (32'(cfg_data) >= 32'(VOICES));
    cfg_count = cfg_full ? CB'(VOICES) : CB'(cfg_data);
    cfg_tail  = cfg_full ? '0 : VB'(cfg_data);
  end

  vca_owner_search #(
    .VOICES   (VOICES),
    .KEY_BITS (KEY_BITS)
  ) u_owner (
    .clk       (clk),
    .rst       (rst),
    .ctl       (octl),
    .key       (key_q),
    .wr_voice  (wr_voice),
    .hit       (hit),
    .hit_voice (hit_voice)
  );

  vca_free_queue #(
    .VOICES (VOICES)
  ) u_queue (
    .clk          (clk),
    .rst          (rst),
    .ctl          (qctl),
    .push_voice   (hit_voice),
    .refill_tail  (cfg_tail),
    .refill_count (cfg_count),
    .head_voice   (qhead),
    .count        (qcount)
  );

  // Decide the outcome once the search has finished
  always_comb begin
    res_ok    = 1'b0;
    res_was   = 1'b0;
    res_stop  = 1'b0;
    res_voice = hit_voice;
    take_pop  = 1'b0;
    take_push = 1'b0;
    case (cmd_q)
      CMD_ASSIGN: begin
        if (hit.found) begin
          res_ok  = 1'b1;
          res_was = 1'b1;
        end else if (qcount != '0) begin
          take_pop  = 1'b1;
          res_ok    = 1'b1;
          res_voice = qhead;
        end
      end
      CMD_RELEASE, CMD_STOP: begin
        if (hit.found) begin
          take_push = 1'b1;
          res_ok    = 1'b1;
          res_stop  = (cmd_q == CMD_STOP);
        end
      end
      CMD_QUERY: begin
        res_ok = hit.found;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
    if (!res_ok) res_voice = '0;

    if (take_pop) begin
      cnt_after    = qcount - 1'b1;
      active_after = active + 1'b1;
    end else if (take_push) begin
      cnt_after    = (qcount != CB'(VOICES)) ? qcount + 1'b1 : qcount;
      active_after = active - 1'b1;
    end else begin
      cnt_after    = qcount;
      active_after = active;
    end
    wr_voice = take_pop ? qhead : hit_voice;
  end

  // Sequencer: accept, scan owner rows, apply and load the result
  always_comb begin
    state_next  = state;
    octl        = '0;
    qctl        = '0;
    load_out    = 1'b0;
    octl.refill = cfg_fire;
    qctl.refill = cfg_fire;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          octl.start = 1'b1;
          qctl.rd    = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit.done) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        // Hold until the output register is free
        load_out = !out_valid || m_axis_tready;
        if (load_out) begin
          qctl.pop   = take_pop;
          qctl.push  = take_push;
          octl.claim = take_pop;
          octl.drop  = take_push;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command beat capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q <= cmd_t'(s_axis_tuser);
      key_q <= KEY_BITS'(s_axis_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cfg_fire) begin
      active <= '0;
    end else if (load_out) begin
      active <= active_after;
    end
  end

  // Output register: a result beat waits here while the next command runs
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {PAD_W'(1'b0), (cnt_after != '0), COUNT_W'(active_after),
                   res_stop, res_was, VOICE_W'(res_voice), res_ok};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

`default_nettype wire

// ===== src/vca_owner_search.sv =====
// Owner table: key memory of eight keys per row plus per-voice valid flops,
// with a row-per-cycle key search. Depends on vca_pkg.
`default_nettype none

module vca_owner_search #(
  parameter int VOICES   = 64,
  parameter int KEY_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire vca_pkg::vca_octl_t          ctl,
  input  wire logic [KEY_BITS-1:0]         key,
  input  wire logic [$clog2(VOICES)-1:0]   wr_voice,
  output vca_pkg::vca_hit_t                hit,
  output logic [$clog2(VOICES)-1:0]        hit_voice
);
  import vca_pkg::*;

  localparam int VB   = $clog2(VOICES);
  localparam int ROWS = (VOICES + LANES - 1) / LANES;
  localparam int RB   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PB   = RB + LANE_BITS;

  logic [LANES*KEY_BITS-1:0] mem [ROWS];
  logic [VOICES-1:0]         valid;
  logic [ROWS*LANES-1:0]     valid_pad;

  logic                      scanning;
  logic [RB-1:0]             rd_row;
  logic                      cmp_en;
  logic [RB-1:0]             cmp_row;
  logic [LANES*KEY_BITS-1:0] rd_data;
  logic [LANES-1:0]          rd_valid;
  logic                      found;
  logic                      done;
  logic [VB-1:0]             voice_r;

  logic [LANES-1:0]          lane_hit;
  logic                      any_hit;
  logic [LANE_BITS-1:0]      hit_lane;
  logic [PB-1:0]             hit_pos;
  logic [PB-1:0]             wr_pos;

  always_comb begin
    valid_pad              = '0;
    valid_pad[VOICES-1:0]  = valid;
    wr_pos                 = PB'(wr_voice);
  end

  // Compare one row of keys, pick the lowest matching lane
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_hit[i] = rd_valid[i] && (rd_data[i*KEY_BITS +: KEY_BITS] == key);
    end
    any_hit  = |lane_hit;
    hit_lane = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (lane_hit[i]) begin
        hit_lane = LANE_BITS'(i);
      end
    end
    hit_pos = {cmp_row, hit_lane};
  end

  always_ff @(posedge clk) begin
    if (ctl.claim) begin
      mem[wr_pos[PB-1:LANE_BITS]][wr_pos[LANE_BITS-1:0]*KEY_BITS +: KEY_BITS] <= key;
    end
    rd_data  <= mem[rd_row];
    rd_valid <= valid_pad[rd_row*LANES +: LANES];
    cmp_row  <= rd_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      scanning <= 1'b0;
      rd_row   <= '0;
      cmp_en   <= 1'b0;
      found    <= 1'b0;
      done     <= 1'b0;
    end else begin
      // pulse once the last row has been compared
      done   <= cmp_en && (cmp_row == RB'(ROWS - 1));
      cmp_en <= scanning;
      if (ctl.refill) begin
        valid <= '0;
      end else begin
        if (ctl.claim) valid[wr_voice] <= 1'b1;
        if (ctl.drop)  valid[wr_voice] <= 1'b0;
      end
      if (scanning) begin
        if (rd_row == RB'(ROWS - 1)) begin
          scanning <= 1'b0;
        end else begin
          rd_row <= rd_row + 1'b1;
        end
      end
      if (cmp_en) begin
        if (any_hit && !found) found <= 1'b1;
      end
      if (ctl.start) begin
        scanning <= 1'b1;
        rd_row   <= '0;
        found    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en && any_hit && !found) begin
      voice_r <= VB'(hit_pos);
    end
  end

  assign hit       = '{done: done, found: found};
  assign hit_voice = voice_r;

endmodule

`default_nettype wire

// ===== src/vca_free_queue.sv =====
// Free-voice FIFO: entry memory, per-entry written flags, head, tail, count.
// An entry never written since refill reads as its own position. Depends on vca_pkg.
`default_nettype none

module vca_free_queue #(
  parameter int VOICES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire vca_pkg::vca_qctl_t            ctl,
  input  wire logic [$clog2(VOICES)-1:0]     push_voice,
  input  wire logic [$clog2(VOICES)-1:0]     refill_tail,
  input  wire logic [$clog2(VOICES+1)-1:0]   refill_count,
  output logic [$clog2(VOICES)-1:0]          head_voice,
  output logic [$clog2(VOICES+1)-1:0]        count
);
  import vca_pkg::*;

  localparam int VB          = $clog2(VOICES);
  localparam int CB          = $clog2(VOICES + 1);
  localparam int RESET_TOTAL = (VOICES < TOTAL_RESET) ? VOICES : TOTAL_RESET;
  localparam int RESET_TAIL  = RESET_TOTAL % VOICES;

  logic [VB-1:0]     q [VOICES];
  logic [VOICES-1:0] written;
  logic [VB-1:0]     head;
  logic [VB-1:0]     tail;
  logic [CB-1:0]     cnt;
  logic [VB-1:0]     rd_data;
  logic              rd_written;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      q[tail] <= push_voice;
    end
    if (ctl.rd) begin
      rd_data    <= q[head];
      rd_written <= written[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= VB'(RESET_TAIL);
      cnt     <= CB'(RESET_TOTAL);
      written <= '0;
    end else if (ctl.refill) begin
      head    <= '0;
      tail    <= refill_tail;
      cnt     <= refill_count;
      written <= '0;
    end else if (ctl.pop) begin
      head <= (head == VB'(VOICES - 1)) ? '0 : head + 1'b1;
      cnt  <= cnt - 1'b1;
    end else if (ctl.push) begin
      written[tail] <= 1'b1;
      tail <= (tail == VB'(VOICES - 1)) ? '0 : tail + 1'b1;
      if (cnt != CB'(VOICES)) cnt <= cnt + 1'b1;
    end
  end

  // Head does not move between the read and its use
  assign head_voice = rd_written ? rd_data : head;
  assign count      = cnt;

endmodule

`default_nettype wire

// ===== sim/voice_channel_allocator_tb.sv =====
// Self-checking testbench for voice_channel_allocator: directed table, then random phases.
// Depends on vca_pkg and the voice_channel_allocator RTL; needs no files or arguments.
module voice_channel_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vca_pkg::*;

  localparam int POOL_MAX        = 64;
  localparam int SETTLE          = 16;    // idle wait before a register write and at the end
  localparam int WATCHDOG_LIMIT  = 4000;  // quiet cycles before giving up
  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
  localparam int MAX_REPORTS     = 10;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 229;
  localparam int PRESSURE_PHASE  = 2;
  localparam int CALM_PHASE      = 3;     // no idling on either side
  localparam bit TYPED           = 1'b1;
  localparam bit PREDICT         = 1'b0;

  // Pool sizes for the random phases; 127 saturates to the full pool
  localparam logic [CFG_W-1:0] PHASE_POOL [N_PHASES] =
    '{7'd64, 7'd4, 7'd127, 7'd23, 7'd64, 7'd5, 7'd41, 7'd64};

  // One result beat, declared from the top bit down so it overlays tdata[16:0]
  typedef struct packed {
    logic               any_free;
    logic [COUNT_W-1:0] active_count;
    logic               stop_request;
    logic               was_playing;
    logic [VOICE_W-1:0] voice;
    logic               ok;
  } voice_reply_t;

  typedef struct {
    bit           is_cfg;
    cmd_t         op;
    logic [15:0]  arg;     // source key, or pool size on a register row
    bit           typed;
    voice_reply_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [15:0] source_key
  logic [CMD_W-1:0]      s_axis_tuser  = '0;  // [1:0] cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [0] ok, [6:1] voice, [7] was_playing, [8] stop_request,
  // [15:9] active_count, [16] any_free, [23:17] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data  = '0;

  // Shadow of the allocator: free-voice FIFO and owner table
  logic [VOICE_W-1:0] idle_fifo [POOL_MAX];
  logic [VOICE_W-1:0] fifo_head;
  logic [VOICE_W-1:0] fifo_tail;
  logic [COUNT_W-1:0] fifo_fill;
  logic [KEY_W-1:0]   holder_key [POOL_MAX];
  bit                 holder_on [POOL_MAX];

  voice_reply_t replies_due [$];
  plan_row_t    plan [$];
  int           mismatches   = 0;
  int           quiet_cycles = 0;
  bit           calm         = 1'b0;
  bit           hold_request = 1'b0;

  voice_channel_allocator #(
    .VOICES  (POOL_MAX),
    .KEY_BITS(KEY_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Refill the FIFO with voices 0..n-1 and forget every owner
  function automatic void reload_pool(logic [CFG_W-1:0] n);
    logic [COUNT_W-1:0] size;
    size = (n > POOL_MAX) ? COUNT_W'(POOL_MAX) : n;
    for (int v = 0; v < POOL_MAX; v++) begin
      idle_fifo[v]  = VOICE_W'(v);
      holder_on[v]  = 1'b0;
      holder_key[v] = '0;
    end
    fifo_head = '0;
    fifo_tail = size[VOICE_W-1:0];  // wraps to 0 for a full pool
    fifo_fill = size;
  endfunction

  // Apply one command to the shadow state and return the beat it must produce
  function automatic voice_reply_t predict_voice_cmd(cmd_t op, logic [KEY_W-1:0] key);
    voice_reply_t r;
    int           hit;
    int           held;
    r    = '0;
    hit  = -1;
    held = 0;
    // scan downward so the lowest matching voice wins
    for (int v = POOL_MAX - 1; v >= 0; v--)
      if (holder_on[v] && holder_key[v] == key) hit = v;
    case (op)
      CMD_ASSIGN: begin
        if (hit >= 0) begin
          r.ok          = 1'b1;
          r.was_playing = 1'b1;
          r.voice       = hit[VOICE_W-1:0];
        end else if (fifo_fill != 0) begin
          r.voice               = idle_fifo[fifo_head];
          fifo_head             = fifo_head + 1'b1;
          fifo_fill             = fifo_fill - 1'b1;
          holder_on[r.voice]    = 1'b1;
          holder_key[r.voice]   = key;
          r.ok                  = 1'b1;
        end
      end
      CMD_RELEASE, CMD_STOP: begin
        if (hit >= 0) begin
          idle_fifo[fifo_tail] = hit[VOICE_W-1:0];
          fifo_tail            = fifo_tail + 1'b1;
          if (fifo_fill < POOL_MAX) fifo_fill = fifo_fill + 1'b1;
          holder_on[hit]       = 1'b0;
          r.ok                 = 1'b1;
          r.voice              = hit[VOICE_W-1:0];
          r.stop_request       = (op == CMD_STOP);
        end
      end
      default: begin
        if (hit >= 0) begin
          r.ok    = 1'b1;
          r.voice = hit[VOICE_W-1:0];
        end
      end
    endcase
    foreach (holder_on[v]) held += holder_on[v];
    r.active_count = held[COUNT_W-1:0];
    r.any_free     = (fifo_fill != 0);
    return r;
  endfunction

  function automatic voice_reply_t reply(int ok, int voice, int was, int stop, int active,
                                         int free);
    voice_reply_t r;
    r.ok           = ok[0];
    r.voice        = voice[VOICE_W-1:0];
    r.was_playing  = was[0];
    r.stop_request = stop[0];
    r.active_count = active[COUNT_W-1:0];
    r.any_free     = free[0];
    return r;
  endfunction

  function automatic void cmd_row(cmd_t op, logic [15:0] key, bit typed, voice_reply_t want);
    plan.insert(plan.size(), '{1'b0, op, key, typed, want});
  endfunction

  function automatic void pool_row(logic [CFG_W-1:0] n);
    plan.insert(plan.size(), '{1'b1, CMD_QUERY, 16'(n), PREDICT, voice_reply_t'('0)});
  endfunction

  function automatic void flag(string what, logic [31:0] want, logic [31:0] got);
    if (mismatches < MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatches++;
  endfunction

  // Compare one result beat, field by field, against the oldest expectation
  function automatic void check_reply(logic [OUT_DATA_W-1:0] beat);
    voice_reply_t got;
    voice_reply_t want;
    got = voice_reply_t'(beat[OUT_FIELDS_W-1:0]);
    if (replies_due.size() == 0) begin
      flag("result beat with nothing outstanding", '0, 32'(beat));
      return;
    end
    want = replies_due.pop_front();
    if (got.ok != want.ok) flag("ok", 32'(want.ok), 32'(got.ok));
    if (got.voice != want.voice) flag("voice", 32'(want.voice), 32'(got.voice));
    if (got.was_playing != want.was_playing) flag("was_playing", 32'(want.was_playing),
                                                  32'(got.was_playing));
    if (got.stop_request != want.stop_request) flag("stop_request", 32'(want.stop_request),
                                                    32'(got.stop_request));
    if (got.active_count != want.active_count) flag("active_count", 32'(want.active_count),
                                                    32'(got.active_count));
    if (got.any_free != want.any_free) flag("any_free", 32'(want.any_free),
                                            32'(got.any_free));
    if (beat[OUT_DATA_W-1:OUT_FIELDS_W] != '0)
      flag("tdata padding", '0, 32'(beat[OUT_DATA_W-1:OUT_FIELDS_W]));
  endfunction

  // Offer one command beat, with a random gap first unless the stretch is calm.
  // Leave tvalid high on return so back-to-back beats need no second assignment.
  task automatic send_voice_cmd(cmd_t op, logic [KEY_W-1:0] key, bit typed,
                                voice_reply_t want);
    voice_reply_t due;
    if (!calm && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < 33);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= op;
    // values read right after the edge are the ones the edge sampled
    do @(posedge clk); while (!s_axis_tready);
    due = predict_voice_cmd(op, key);
    replies_due.insert(replies_due.size(), typed ? want : due);
  endtask

  // Hold the command side until every result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // Write the pool size only once the block has gone idle
  task automatic write_pool(logic [CFG_W-1:0] n);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reload_pool(n);
  endtask

  // Result side: check accepted beats, then pick tready for the next edge.
  // A hold request holds tready low so the block backs up.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) check_reply(m_axis_tdata);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 33);
      end
    end
  end

  // Watchdog: end the run when no beat of any kind moves for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no beat accepted for %0d cycles", $time, quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int               eff;
    int               span;
    int               pick;
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] key;
    cmd_t             op;

    reload_pool(CFG_W'(TOTAL_RESET));

    // Directed table. Columns of reply(): ok, voice, was_playing, stop_request,
    // active_count, any_free.
    // Reset state: full pool, no owners; extreme keys 0x0000 and 0xFFFF.
    cmd_row(CMD_QUERY,   16'h0000, TYPED, reply(0, 0, 0, 0, 0, 1));
    cmd_row(CMD_ASSIGN,  16'h0000, TYPED, reply(1, 0, 0, 0, 1, 1));
    cmd_row(CMD_ASSIGN,  16'hFFFF, TYPED, reply(1, 1, 0, 0, 2, 1));
    cmd_row(CMD_ASSIGN,  16'hFFFF, TYPED, reply(1, 1, 1, 0, 2, 1));  // already holds
    cmd_row(CMD_QUERY,   16'hFFFF, TYPED, reply(1, 1, 0, 0, 2, 1));
    cmd_row(CMD_RELEASE, 16'h0000, TYPED, reply(1, 0, 0, 0, 1, 1));
    cmd_row(CMD_RELEASE, 16'h0000, TYPED, reply(0, 0, 0, 0, 1, 1));  // holds nothing
    cmd_row(CMD_STOP,    16'hFFFF, TYPED, reply(1, 1, 0, 1, 0, 1));
    cmd_row(CMD_STOP,    16'h1234, TYPED, reply(0, 0, 0, 0, 0, 1));
    // Smallest legal pool: exhaust it, fail, then reuse the voice freed at the tail
    pool_row(7'd4);
    cmd_row(CMD_ASSIGN,  16'hA5A5, TYPED, reply(1, 0, 0, 0, 1, 1));
    cmd_row(CMD_ASSIGN,  16'h5A5A, TYPED, reply(1, 1, 0, 0, 2, 1));
    cmd_row(CMD_ASSIGN,  16'h0001, TYPED, reply(1, 2, 0, 0, 3, 1));
    cmd_row(CMD_ASSIGN,  16'h8000, TYPED, reply(1, 3, 0, 0, 4, 0));
    cmd_row(CMD_ASSIGN,  16'h7777, TYPED, reply(0, 0, 0, 0, 4, 0));  // pool exhausted
    cmd_row(CMD_RELEASE, 16'h5A5A, TYPED, reply(1, 1, 0, 0, 3, 1));
    cmd_row(CMD_ASSIGN,  16'h7777, TYPED, reply(1, 1, 0, 0, 4, 0));
    // Empty pool: every assign fails
    pool_row(7'd0);
    cmd_row(CMD_ASSIGN,  16'h0042, TYPED, reply(0, 0, 0, 0, 0, 0));
    // Oversized value saturates to the full pool
    pool_row(7'd127);
    cmd_row(CMD_ASSIGN,  16'h0042, TYPED, reply(1, 0, 0, 0, 1, 1));
    // Rewriting the same size still clears every owner
    pool_row(7'd64);
    cmd_row(CMD_QUERY,   16'h0042, TYPED, reply(0, 0, 0, 0, 0, 1));
    // Pool below the legal floor is taken as given
    pool_row(7'd3);
    cmd_row(CMD_ASSIGN,  16'h0100, PREDICT, voice_reply_t'('0));
    cmd_row(CMD_ASSIGN,  16'h0200, PREDICT, voice_reply_t'('0));
    cmd_row(CMD_ASSIGN,  16'h0300, TYPED, reply(1, 2, 0, 0, 3, 0));
    cmd_row(CMD_ASSIGN,  16'h0400, TYPED, reply(0, 0, 0, 0, 3, 0));

    // Hold reset, then release it for good
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_pool(plan[i].arg[CFG_W-1:0]);
      end else begin
        send_voice_cmd(plan[i].op, plan[i].arg, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: keys come mostly from a small set around a random base,
    // about one and a half times the pool, so the pool fills, drains and
    // recycles voices; one key in ten is fully random noise.
    for (int p = 0; p < N_PHASES; p++) begin
      write_pool(PHASE_POOL[p]);
      eff  = (PHASE_POOL[p] > POOL_MAX) ? POOL_MAX : int'(PHASE_POOL[p]);
      span = eff + eff / 2 + 1;
      base = KEY_W'($urandom);
      calm = (p == CALM_PHASE);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // stall the result side while commands keep coming
        if (p == PRESSURE_PHASE && i == 60) hold_request = 1'b1;
        // pause the sender until the block has answered everything
        if (p == PRESSURE_PHASE && i == 150) drain_results();
        pick = $urandom_range(99);
        if (pick < 40) op = CMD_ASSIGN;
        else if (pick < 60) op = CMD_RELEASE;
        else if (pick < 75) op = CMD_STOP;
        else op = CMD_QUERY;
        if ($urandom_range(9) == 0) key = KEY_W'($urandom);
        else key = base ^ KEY_W'($urandom_range(span - 1));
        send_voice_cmd(op, key, PREDICT, voice_reply_t'('0));
      end
    end
    calm = 1'b0;

    // Let the last results arrive, then keep the clock running to catch strays
    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/vca_pkg.sv
src/vca_owner_search.sv
src/vca_free_queue.sv
src/voice_channel_allocator.sv
sim/voice_channel_allocator_tb.sv
